FILE: hw/rtl/least_squares_scale_offset_fit_assert.svh
// Assertion macros for the least-squares fit block.
// Included by the top level; expects clk and rst in scope.
`ifndef LEAST_SQUARES_SCALE_OFFSET_FIT_ASSERT_SVH
`define LEAST_SQUARES_SCALE_OFFSET_FIT_ASSERT_SVH

// same-cycle implication
`define LSSOF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LSSOF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/lssof_pkg.sv
// Shared types, constants and helpers for the least-squares fit block.
// No dependencies.
`timescale 1ns / 1ps
package lssof_pkg;

  localparam int MAX_PAIRS = 65536;
  localparam int CNT_W     = 17;
  localparam int MUL_STEPS = 33;
  localparam int DIV_STEPS = 81;
  localparam int STEP_W    = 7;

  localparam logic [31:0] SCALE_ONE = 32'h0001_0000;
  localparam logic [31:0] SAT_POS   = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG   = 32'h8000_0000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MLOAD, ST_MSTEP, ST_MSAVE, ST_CHECK,
    ST_DLOAD, ST_DSTEP, ST_DSAVE, ST_OUT
  } ctl_state_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_MUL_LOAD, DP_MUL_STEP, DP_SAVE_TMP, DP_SAVE_NUM, DP_SAVE_DEN,
    DP_SAVE_BN, DP_A_ONE, DP_DIV_LOAD, DP_DIV_STEP, DP_SAVE_A, DP_SAVE_B, DP_OUT
  } dp_op_t;

  // multiply phase: which product is formed
  typedef enum logic [2:0] {
    SEL_NXY, SEL_XY, SEL_NXX, SEL_XX, SEL_AX
  } opnd_sel_t;

  typedef struct packed {
    dp_op_t    op;
    opnd_sel_t sel;
    logic      msb;
  } dp_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic out_free;
  } dp_stat_t;

  function automatic logic [31:0] sat32(input logic neg, input logic big,
                                        input logic [32:0] q);
    logic [31:0] r;
    if (big || q[32] || q[31]) begin
      r = neg ? SAT_NEG : SAT_POS;
    end else if (neg) begin
      r = ~q[31:0] + 32'd1;
    end else begin
      r = q[31:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/lssof_if.sv
// Request channels for the least-squares fit block: sample pairs in, fits out.
// No dependencies.
`timescale 1ns / 1ps
interface lssof_pair_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] estimated_value;
  logic signed [15:0] target_value;
  logic               last_pair;
  modport source (output valid, estimated_value, target_value, last_pair, input ready);
  modport sink (input valid, estimated_value, target_value, last_pair, output ready);
endinterface

interface lssof_fit_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] scale_factor;
  logic signed [31:0] offset_term;
  logic               degenerate;
  logic [16:0]        pair_count;
  modport source (output valid, scale_factor, offset_term, degenerate, pair_count,
                  input ready);
  modport sink (input valid, scale_factor, offset_term, degenerate, pair_count,
                output ready);
endinterface

FILE: hw/rtl/lssof_ctrl.sv
// Sequencer for the fit: five serial multiplies, up to two serial divides, output.
// Depends on lssof_pkg.
`timescale 1ns / 1ps
module lssof_ctrl import lssof_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     idle
);

  ctl_state_t        state, state_next;
  opnd_sel_t         phase, phase_next;
  logic [STEP_W-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= SEL_NXY;
      step  <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    step_next  = step;
    cmd        = '{op: DP_NOP, sel: phase, msb: 1'b0};
    idle       = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_MLOAD;
          phase_next = SEL_NXY;
        end
      end
      ST_MLOAD: begin
        cmd.op     = DP_MUL_LOAD;
        step_next  = '0;
        state_next = ST_MSTEP;
      end
      ST_MSTEP: begin
        cmd.op  = DP_MUL_STEP;
        cmd.msb = (step == STEP_W'(MUL_STEPS - 1));
        if (cmd.msb) begin
          state_next = ST_MSAVE;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      ST_MSAVE: begin
        case (phase)
          SEL_NXY: begin
            cmd.op = DP_SAVE_TMP; phase_next = SEL_XY; state_next = ST_MLOAD;
          end
          SEL_XY: begin
            cmd.op = DP_SAVE_NUM; phase_next = SEL_NXX; state_next = ST_MLOAD;
          end
          SEL_NXX: begin
            cmd.op = DP_SAVE_TMP; phase_next = SEL_XX; state_next = ST_MLOAD;
          end
          SEL_XX: begin
            cmd.op = DP_SAVE_DEN; state_next = ST_CHECK;
          end
          SEL_AX: begin
            cmd.op = DP_SAVE_BN; state_next = ST_DLOAD;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_CHECK: begin
        if (stat.den_zero) begin
          cmd.op     = DP_A_ONE;
          phase_next = SEL_AX;
          state_next = ST_MLOAD;
        end else begin
          state_next = ST_DLOAD;
        end
      end
      ST_DLOAD: begin
        cmd.op     = DP_DIV_LOAD;
        step_next  = '0;
        state_next = ST_DSTEP;
      end
      ST_DSTEP: begin
        cmd.op = DP_DIV_STEP;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = ST_DSAVE;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      ST_DSAVE: begin
        if (phase == SEL_AX) begin
          cmd.op     = DP_SAVE_B;
          state_next = ST_OUT;
        end else begin
          cmd.op     = DP_SAVE_A;
          phase_next = SEL_AX;
          state_next = ST_MLOAD;
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.op     = DP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/lssof_dp.sv
// Datapath: running sums, shift-add multiplier, restoring divider, result register.
// Depends on lssof_pkg.
`timescale 1ns / 1ps
module lssof_dp import lssof_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic signed [15:0] x,
  input  logic signed [15:0] y,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_scale,
  output logic signed [31:0] out_offset,
  output logic               out_degen,
  output logic [CNT_W-1:0]   out_count
);

  logic [CNT_W-1:0] cnt;
  logic [32:0]      sx, sy;
  logic [46:0]      sxx;
  logic [47:0]      sxy;

  logic [63:0] m_a, prod, tmp, num, den;
  logic [32:0] m_b;

  logic [80:0] dvd;
  logic [64:0] dvs;
  logic [63:0] rem;
  logic [32:0] quot;
  logic        big, qneg;

  logic [31:0] a_reg, b_reg;
  logic        degen;

  logic signed [31:0] xx, xy;
  logic [64:0]        r_sh, r_sub;
  logic               ge;
  logic [63:0]        src, mag;

  assign xx = x * x;
  assign xy = x * y;

  assign r_sh  = {rem, dvd[80]};
  assign ge    = (r_sh >= dvs);
  assign r_sub = r_sh - dvs;

  assign src = (cmd.sel == SEL_AX) ? tmp : num;
  assign mag = src[63] ? (~src + 64'd1) : src;

  assign stat.den_zero = (den == '0);
  assign stat.out_free = !out_valid || out_ready;

  // running sums; a full set drops further pairs
  always_ff @(posedge clk) begin
    if (rst || cmd.op == DP_OUT) begin
      cnt <= '0;
      sx  <= '0;
      sy  <= '0;
      sxx <= '0;
      sxy <= '0;
    end else if (accept && cnt != CNT_W'(MAX_PAIRS)) begin
      cnt <= cnt + CNT_W'(1);
      sx  <= sx + {{17{x[15]}}, x};
      sy  <= sy + {{17{y[15]}}, y};
      sxx <= sxx + {15'b0, xx};
      sxy <= sxy + {{16{xy[31]}}, xy};
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_MUL_LOAD: begin
        prod <= '0;
        case (cmd.sel)
          SEL_NXY: begin m_a <= {{16{sxy[47]}}, sxy}; m_b <= {16'b0, cnt}; end
          SEL_XY:  begin m_a <= {{31{sx[32]}}, sx};   m_b <= sy;           end
          SEL_NXX: begin m_a <= {17'b0, sxx};         m_b <= {16'b0, cnt}; end
          SEL_XX:  begin m_a <= {{31{sx[32]}}, sx};   m_b <= sx;           end
          default: begin m_a <= {{31{sx[32]}}, sx};   m_b <= {a_reg[31], a_reg}; end
        endcase
      end
      DP_MUL_STEP: begin
        // top multiplier bit carries negative weight
        if (m_b[0]) begin
          prod <= cmd.msb ? (prod - m_a) : (prod + m_a);
        end
        m_a <= m_a << 1;
        m_b <= m_b >> 1;
      end
      DP_SAVE_TMP: tmp <= prod;
      DP_SAVE_NUM: num <= tmp - prod;
      DP_SAVE_DEN: den <= tmp - prod;
      DP_SAVE_BN:  tmp <= {{15{sy[32]}}, sy, 16'b0} - prod;
      DP_A_ONE: begin
        a_reg <= SCALE_ONE;
        degen <= 1'b1;
      end
      DP_DIV_LOAD: begin
        qneg <= src[63];
        rem  <= '0;
        quot <= '0;
        big  <= 1'b0;
        if (cmd.sel == SEL_AX) begin
          dvd <= {17'b0, mag} + {53'b0, cnt, 11'b0};
          dvs <= {36'b0, cnt, 12'b0};
        end else begin
          // round(num * 2^16 / den) = floor((num * 2^17 + den) / (2 * den))
          dvd <= {mag, 17'b0} + {17'b0, den};
          dvs <= {den, 1'b0};
        end
      end
      DP_DIV_STEP: begin
        dvd  <= dvd << 1;
        rem  <= ge ? r_sub[63:0] : r_sh[63:0];
        quot <= {quot[31:0], ge};
        big  <= big | quot[32];
      end
      DP_SAVE_A: begin
        a_reg <= sat32(qneg, big, quot);
        degen <= 1'b0;
      end
      DP_SAVE_B: b_reg <= sat32(qneg, big, quot);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == DP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_OUT) begin
      out_scale  <= a_reg;
      out_offset <= b_reg;
      out_degen  <= degen;
      out_count  <= cnt;
    end
  end

endmodule

FILE: hw/rtl/least_squares_scale_offset_fit.sv
// A pair without the last mark is taken while the block is idle, one pair per cycle.
// A last pair starts the fit: five 33-step shift-add multiplies and two 81-step
// restoring divides, or only one divide when the x variance is zero; no pair is
// taken until the fit has been handed to the result register.
// The result register holds one fit while the next set accumulates.
// Synchronous reset clears the sums, the sequencer and the result valid.
`timescale 1ns / 1ps
module least_squares_scale_offset_fit import lssof_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  lssof_pair_if.sink  pair_in,
  lssof_fit_if.source fit_out
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     idle;
  logic     accept;

  assign pair_in.ready = idle;
  assign accept        = pair_in.valid && idle;

  lssof_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (accept && pair_in.last_pair),
    .stat  (stat),
    .cmd   (cmd),
    .idle  (idle)
  );

  lssof_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .x          (pair_in.estimated_value),
    .y          (pair_in.target_value),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (fit_out.valid),
    .out_ready  (fit_out.ready),
    .out_scale  (fit_out.scale_factor),
    .out_offset (fit_out.offset_term),
    .out_degen  (fit_out.degenerate),
    .out_count  (fit_out.pair_count)
  );

`include "least_squares_scale_offset_fit_assert.svh"

  `LSSOF_ASSERT_NXT(a_busy_after_last, accept && pair_in.last_pair, !pair_in.ready, "pair taken during fit")
  `LSSOF_ASSERT_IMP(a_count_nonzero, fit_out.valid, fit_out.pair_count != '0, "empty set fitted")
  `LSSOF_ASSERT_IMP(a_degen_scale, fit_out.valid && fit_out.degenerate, fit_out.scale_factor == SCALE_ONE, "degenerate scale not one")

endmodule
